// File: hdl/fdmd_pkg.sv
// ----------------------------------------------------------------------------
// fdmd_pkg
// Shared types and constants of the frame difference motion detector:
// configuration register layout, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package fdmd_pkg;

	localparam int unsigned CFG_ADDR_W = 5;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned LEVEL_W    = 8;
	localparam int unsigned COUNT_W    = 23;
	localparam int unsigned SIZE_W     = 12;
	localparam int unsigned PIXEL_W    = 16;
	localparam int unsigned DIFF_W     = 8;

	typedef enum logic [2:0] {
		REG_PIXEL_MODE      = 3'd0,
		REG_LEVEL_THRESHOLD = 3'd1,
		REG_COUNT_THRESHOLD = 3'd2,
		REG_FRAME_WIDTH     = 3'd3,
		REG_FRAME_HEIGHT    = 3'd4
	} reg_index_t;

	localparam logic               MODE_RST   = 1'b0;
	localparam logic [LEVEL_W-1:0] LEVEL_RST  = 8'd20;
	localparam logic [COUNT_W-1:0] COUNT_RST  = 23'd300;
	localparam logic [SIZE_W-1:0]  WIDTH_RST  = 12'd320;
	localparam logic [SIZE_W-1:0]  HEIGHT_RST = 12'd240;

	// The changed-pixel count saturates here.
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 23'd4194304;

	// RGB565 channel masks.
	localparam logic [PIXEL_W-1:0] RED_BITS   = 16'hF800;
	localparam logic [PIXEL_W-1:0] GREEN_BITS = 16'h07E0;
	localparam logic [PIXEL_W-1:0] BLUE_BITS  = 16'h001F;

	typedef struct packed {
		logic               pixel_mode;
		logic [LEVEL_W-1:0] level_threshold;
		logic [COUNT_W-1:0] count_threshold;
		logic [SIZE_W-1:0]  frame_width;
		logic [SIZE_W-1:0]  frame_height;
	} cfg_t;

	// Handshake between the input register and the frame accumulator.
	typedef struct packed {
		logic valid;
		logic changed;
	} pix_ctl_t;

endpackage

`default_nettype wire

// File: hdl/fdmd_regs.sv
// ----------------------------------------------------------------------------
// fdmd_regs
// APB-style configuration register file of the motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [fdmd_pkg::CFG_ADDR_W-1:0]    paddr,
	input  wire logic [fdmd_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic      [fdmd_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                                    pready,
	output fdmd_pkg::cfg_t                          cfg
);

	fdmd_pkg::cfg_t cfg_q;
	logic [2:0]     index;
	logic           wr_en;

	assign index  = paddr[4:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_mode      <= fdmd_pkg::MODE_RST;
			cfg_q.level_threshold <= fdmd_pkg::LEVEL_RST;
			cfg_q.count_threshold <= fdmd_pkg::COUNT_RST;
			cfg_q.frame_width     <= fdmd_pkg::WIDTH_RST;
			cfg_q.frame_height    <= fdmd_pkg::HEIGHT_RST;
		end else if (wr_en) begin
			unique case (index)
				fdmd_pkg::REG_PIXEL_MODE:      cfg_q.pixel_mode      <= pwdata[0];
				fdmd_pkg::REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= pwdata[7:0];
				fdmd_pkg::REG_COUNT_THRESHOLD: cfg_q.count_threshold <= pwdata[22:0];
				fdmd_pkg::REG_FRAME_WIDTH:     cfg_q.frame_width     <= pwdata[11:0];
				fdmd_pkg::REG_FRAME_HEIGHT:    cfg_q.frame_height    <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (index)
			fdmd_pkg::REG_PIXEL_MODE:      prdata[0]    = cfg_q.pixel_mode;
			fdmd_pkg::REG_LEVEL_THRESHOLD: prdata[7:0]  = cfg_q.level_threshold;
			fdmd_pkg::REG_COUNT_THRESHOLD: prdata[22:0] = cfg_q.count_threshold;
			fdmd_pkg::REG_FRAME_WIDTH:     prdata[11:0] = cfg_q.frame_width;
			fdmd_pkg::REG_FRAME_HEIGHT:    prdata[11:0] = cfg_q.frame_height;
			default:                       prdata       = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: hdl/fdmd_diff.sv
// ----------------------------------------------------------------------------
// fdmd_diff
// Pixel difference and level compare: RGB565 channel sum or gray byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_diff (
	input  wire logic                             pixel_mode,
	input  wire logic [fdmd_pkg::LEVEL_W-1:0]     level_threshold,
	input  wire logic [fdmd_pkg::PIXEL_W-1:0]     pixel_first,
	input  wire logic [fdmd_pkg::PIXEL_W-1:0]     pixel_second,
	output logic                                  changed
);

	logic [4:0]                    r1, r2, b1, b2, dr, db;
	logic [5:0]                    g1, g2, dg;
	logic [7:0]                    y1, y2, dy;
	logic [fdmd_pkg::DIFF_W-1:0]   diff;
	logic [fdmd_pkg::PIXEL_W-1:0]  m1r, m2r, m1g, m2g, m1b, m2b;

	always_comb begin
		m1r = pixel_first  & fdmd_pkg::RED_BITS;
		m2r = pixel_second & fdmd_pkg::RED_BITS;
		m1g = pixel_first  & fdmd_pkg::GREEN_BITS;
		m2g = pixel_second & fdmd_pkg::GREEN_BITS;
		m1b = pixel_first  & fdmd_pkg::BLUE_BITS;
		m2b = pixel_second & fdmd_pkg::BLUE_BITS;
		r1 = m1r[15:11];
		r2 = m2r[15:11];
		g1 = m1g[10:5];
		g2 = m2g[10:5];
		b1 = m1b[4:0];
		b2 = m2b[4:0];
		y1 = pixel_first[7:0];
		y2 = pixel_second[7:0];
		dr = (r1 > r2) ? r1 - r2 : r2 - r1;
		dg = (g1 > g2) ? g1 - g2 : g2 - g1;
		db = (b1 > b2) ? b1 - b2 : b2 - b1;
		dy = (y1 > y2) ? y1 - y2 : y2 - y1;
		// The channel sum peaks at 125, so it never overflows the byte.
		if (pixel_mode) begin
			diff = dy;
		end else begin
			diff = 8'(dr) + 8'(dg) + 8'(db);
		end
		changed = diff > level_threshold;
	end

endmodule

`default_nettype wire

// File: hdl/fdmd_accum.sv
// ----------------------------------------------------------------------------
// fdmd_accum
// Raster position counters, changed-pixel count, bounding box and the
// result register that carries one word per frame.
// ----------------------------------------------------------------------------
`default_nettype none

module fdmd_accum #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048,
	localparam int unsigned CW = $clog2(MAX_WIDTH),
	localparam int unsigned RW = $clog2(MAX_HEIGHT),
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
	localparam int unsigned HW = $clog2(MAX_HEIGHT + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire fdmd_pkg::cfg_t                  cfg,
	input  wire fdmd_pkg::pix_ctl_t              pix,
	output logic                                 advance,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 motion_detected,
	output logic [fdmd_pkg::COUNT_W-1:0]         changed_count,
	output logic [WW-1:0]                        box_left,
	output logic [HW-1:0]                        box_top,
	output logic [CW-1:0]                        box_right,
	output logic [RW-1:0]                        box_bottom
);

	localparam int unsigned LEFT_RST_I =
		(32'(fdmd_pkg::WIDTH_RST) > MAX_WIDTH) ? MAX_WIDTH : 32'(fdmd_pkg::WIDTH_RST);
	localparam int unsigned TOP_RST_I =
		(32'(fdmd_pkg::HEIGHT_RST) > MAX_HEIGHT) ? MAX_HEIGHT : 32'(fdmd_pkg::HEIGHT_RST);
	localparam logic [WW-1:0] LEFT_RST = WW'(LEFT_RST_I);
	localparam logic [HW-1:0] TOP_RST  = HW'(TOP_RST_I);

	logic [CW-1:0]                col_q;
	logic [RW-1:0]                row_q;
	logic [fdmd_pkg::COUNT_W-1:0] total_q, total_n;
	logic [WW-1:0]                left_q, left_n;
	logic [HW-1:0]                top_q, top_n;
	logic [CW-1:0]                right_q, right_n;
	logic [RW-1:0]                bottom_q, bottom_n;
	logic [WW-1:0]                eff_w;
	logic [HW-1:0]                eff_h;
	logic                         row_end, frame_end, out_valid_q;

	// Effective frame size: zero acts as one, oversize clamps to the maximum.
	always_comb begin
		if (cfg.frame_width == '0) begin
			eff_w = WW'(1);
		end else if (32'(cfg.frame_width) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			eff_h = HW'(1);
		end else if (32'(cfg.frame_height) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(cfg.frame_height);
		end
	end

	always_comb begin
		row_end   = (32'(col_q) + 32'd1) >= 32'(eff_w);
		frame_end = row_end && ((32'(row_q) + 32'd1) >= 32'(eff_h));
		// Pixels inside a frame move on even while a finished word waits.
		advance   = pix.valid && (!frame_end || !out_valid_q || !out_stall);

		total_n  = total_q;
		left_n   = left_q;
		top_n    = top_q;
		right_n  = right_q;
		bottom_n = bottom_q;
		if (pix.changed) begin
			if (total_q < fdmd_pkg::COUNT_LIMIT) begin
				total_n = total_q + 1'b1;
			end
			if (32'(col_q) < 32'(left_q)) begin
				left_n = WW'(col_q);
			end
			if (32'(row_q) < 32'(top_q)) begin
				top_n = HW'(row_q);
			end
			if (col_q > right_q) begin
				right_n = col_q;
			end
			if (row_q > bottom_q) begin
				bottom_n = row_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			total_q  <= '0;
			left_q   <= LEFT_RST;
			top_q    <= TOP_RST;
			right_q  <= '0;
			bottom_q <= '0;
		end else if (advance) begin
			if (frame_end) begin
				col_q    <= '0;
				row_q    <= '0;
				total_q  <= '0;
				left_q   <= eff_w;
				top_q    <= eff_h;
				right_q  <= '0;
				bottom_q <= '0;
			end else begin
				total_q  <= total_n;
				left_q   <= left_n;
				top_q    <= top_n;
				right_q  <= right_n;
				bottom_q <= bottom_n;
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && frame_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end) begin
			motion_detected <= total_n > cfg.count_threshold;
			changed_count   <= total_n;
			if (total_n == '0) begin
				box_left   <= eff_w;
				box_top    <= eff_h;
				box_right  <= '0;
				box_bottom <= '0;
			end else begin
				box_left   <= left_n;
				box_top    <= top_n;
				box_right  <= right_n;
				box_bottom <= bottom_n;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// File: hdl/frame_difference_motion_detect.sv
// ----------------------------------------------------------------------------
// frame_difference_motion_detect
// Compares two frames pixel by pixel and reports, once per frame, a motion
// flag, the changed-pixel count and the bounding box of the changes.
//
// Usage: pixel pairs (earlier and later frame, same position) enter on the
// in channel in raster order, one word per cycle at full rate. The position
// is counted against frame_width and frame_height from the APB registers.
// Each pair is captured in an input register, scored from there and added
// to the counters and box registers as it leaves; after the last pixel of a
// frame one result word appears on the out channel from a result register.
// Sustained throughput is one pixel per cycle while no pending result is
// stalled at a frame's end. While the receiver stalls a pending result,
// pixels of the next frame keep flowing; only the last pixel of that next
// frame is held in the input register, and in_stall rises, until the
// pending word is taken.
// Reset clears the counters, empties the box and loads the register
// defaults (RGB565, level 20, count 300, 320 by 240).
// ----------------------------------------------------------------------------
`default_nettype none

module frame_difference_motion_detect #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [fdmd_pkg::CFG_ADDR_W-1:0]       paddr,
	input  wire logic [fdmd_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic      [fdmd_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                       pready,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [fdmd_pkg::PIXEL_W-1:0]          pixel_first,
	input  wire logic [fdmd_pkg::PIXEL_W-1:0]          pixel_second,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       motion_detected,
	output logic [fdmd_pkg::COUNT_W-1:0]               changed_count,
	output logic [$clog2(MAX_WIDTH + 1)-1:0]           box_left,
	output logic [$clog2(MAX_HEIGHT + 1)-1:0]          box_top,
	output logic [$clog2(MAX_WIDTH)-1:0]               box_right,
	output logic [$clog2(MAX_HEIGHT)-1:0]              box_bottom
);

	fdmd_pkg::cfg_t                 cfg;
	fdmd_pkg::pix_ctl_t             pix;
	logic                           valid_s1;
	logic [fdmd_pkg::PIXEL_W-1:0]   first_s1, second_s1;
	logic                           changed;
	logic                           advance;
	logic                           accept;

	fdmd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1  <= pixel_first;
			second_s1 <= pixel_second;
		end
	end

	fdmd_diff u_diff (
		.pixel_mode      (cfg.pixel_mode),
		.level_threshold (cfg.level_threshold),
		.pixel_first     (first_s1),
		.pixel_second    (second_s1),
		.changed         (changed)
	);

	assign pix.valid   = valid_s1;
	assign pix.changed = changed;

	fdmd_accum #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_accum (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.pix             (pix),
		.advance         (advance),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.motion_detected (motion_detected),
		.changed_count   (changed_count),
		.box_left        (box_left),
		.box_top         (box_top),
		.box_right       (box_right),
		.box_bottom      (box_bottom)
	);

endmodule

`default_nettype wire

// File: tb/fdmd_checker.sv
// ----------------------------------------------------------------------------
// fdmd_checker
// Watches the APB port and both pixel channels of the frame difference motion
// detector. It keeps its own copy of the registers and the running frame
// state, scores every accepted pixel pair, works out the expected report
// of each frame, and compares each report word taken field by field.
// ----------------------------------------------------------------------------
module fdmd_checker #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [fdmd_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [fdmd_pkg::CFG_DATA_W-1:0]       pwdata,
	input  logic                                  pready,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [fdmd_pkg::PIXEL_W-1:0]          pixel_first,
	input  logic [fdmd_pkg::PIXEL_W-1:0]          pixel_second,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic                                  motion_detected,
	input  logic [fdmd_pkg::COUNT_W-1:0]          changed_count,
	input  logic [$clog2(MAX_WIDTH + 1)-1:0]      box_left,
	input  logic [$clog2(MAX_HEIGHT + 1)-1:0]     box_top,
	input  logic [$clog2(MAX_WIDTH)-1:0]          box_right,
	input  logic [$clog2(MAX_HEIGHT)-1:0]         box_bottom,
	output int                                    failures,
	output int                                    pending_reports
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LEFT_W   = $clog2(MAX_WIDTH + 1);
	localparam int unsigned TOP_W    = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned RIGHT_W  = $clog2(MAX_WIDTH);
	localparam int unsigned BOTTOM_W = $clog2(MAX_HEIGHT);

	typedef struct {
		logic                         motion;
		logic [fdmd_pkg::COUNT_W-1:0] count;
		logic [LEFT_W-1:0]            left;
		logic [TOP_W-1:0]             top;
		logic [RIGHT_W-1:0]           right;
		logic [BOTTOM_W-1:0]          bottom;
	} frame_report_t;

	frame_report_t report_q[$];
	int fail_total = 0;

	logic                         gray_mode;
	logic [fdmd_pkg::LEVEL_W-1:0] level_thr;
	logic [fdmd_pkg::COUNT_W-1:0] count_thr;
	logic [fdmd_pkg::SIZE_W-1:0]  width_reg;
	logic [fdmd_pkg::SIZE_W-1:0]  height_reg;

	int unsigned col_idx, row_idx, change_count;
	int unsigned left_edge, top_edge, right_edge, bottom_edge;

	// A size of zero acts as one, anything above the maximum as the maximum.
	function automatic int unsigned clamp_size(input logic [fdmd_pkg::SIZE_W-1:0] v,
			input int unsigned maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return v;
	endfunction

	function automatic int unsigned absdist(input int unsigned a, input int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	task automatic clear_frame_state();
		col_idx = 0;
		row_idx = 0;
		change_count = 0;
		left_edge = clamp_size(width_reg, MAX_WIDTH);
		top_edge = clamp_size(height_reg, MAX_HEIGHT);
		right_edge = 0;
		bottom_edge = 0;
	endtask

	task automatic apply_write(input logic [fdmd_pkg::CFG_ADDR_W-1:0] addr,
			input logic [fdmd_pkg::CFG_DATA_W-1:0] data);
		case (fdmd_pkg::reg_index_t'(addr[fdmd_pkg::CFG_ADDR_W-1:2]))
			fdmd_pkg::REG_PIXEL_MODE:      gray_mode = data[0];
			fdmd_pkg::REG_LEVEL_THRESHOLD: level_thr = data[fdmd_pkg::LEVEL_W-1:0];
			fdmd_pkg::REG_COUNT_THRESHOLD: count_thr = data[fdmd_pkg::COUNT_W-1:0];
			fdmd_pkg::REG_FRAME_WIDTH:     width_reg = data[fdmd_pkg::SIZE_W-1:0];
			fdmd_pkg::REG_FRAME_HEIGHT:    height_reg = data[fdmd_pkg::SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// Scores one pixel pair, advances the raster position and queues the
	// frame report when this word closes the frame.
	task automatic score_pixel(input logic [fdmd_pkg::PIXEL_W-1:0] a,
			input logic [fdmd_pkg::PIXEL_W-1:0] b);
		int unsigned w, h, d;
		frame_report_t r;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		if (gray_mode) begin
			d = absdist(a[7:0], b[7:0]);
		end else begin
			d = absdist((a & fdmd_pkg::RED_BITS) >> 11, (b & fdmd_pkg::RED_BITS) >> 11)
				+ absdist((a & fdmd_pkg::GREEN_BITS) >> 5, (b & fdmd_pkg::GREEN_BITS) >> 5)
				+ absdist(a & fdmd_pkg::BLUE_BITS, b & fdmd_pkg::BLUE_BITS);
		end
		if (d > level_thr) begin
			if (change_count < fdmd_pkg::COUNT_LIMIT) change_count++;
			if (col_idx < left_edge) left_edge = col_idx;
			if (row_idx < top_edge) top_edge = row_idx;
			if (col_idx > right_edge) right_edge = col_idx;
			if (row_idx > bottom_edge) bottom_edge = row_idx;
		end
		if (col_idx + 1 < w) begin
			col_idx++;
		end else begin
			col_idx = 0;
			if (row_idx + 1 < h) begin
				row_idx++;
			end else begin
				r.motion = (change_count > count_thr);
				r.count = fdmd_pkg::COUNT_W'(change_count);
				if (change_count == 0) begin
					r.left = LEFT_W'(w);
					r.top = TOP_W'(h);
					r.right = '0;
					r.bottom = '0;
				end else begin
					r.left = LEFT_W'(left_edge);
					r.top = TOP_W'(top_edge);
					r.right = RIGHT_W'(right_edge);
					r.bottom = BOTTOM_W'(bottom_edge);
				end
				report_q.push_back(r);
				clear_frame_state();
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_total++;
		end
	endtask

	task automatic check_report();
		frame_report_t r;
		if (report_q.size() == 0) begin
			$display("%0t: report word with none expected, expected none, actual count %0d",
				$time, changed_count);
			fail_total++;
		end else begin
			r = report_q.pop_front();
			check_field("motion_detected", r.motion, motion_detected);
			check_field("changed_count", r.count, changed_count);
			check_field("box_left", r.left, box_left);
			check_field("box_top", r.top, box_top);
			check_field("box_right", r.right, box_right);
			check_field("box_bottom", r.bottom, box_bottom);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_mode = fdmd_pkg::MODE_RST;
			level_thr = fdmd_pkg::LEVEL_RST;
			count_thr = fdmd_pkg::COUNT_RST;
			width_reg = fdmd_pkg::WIDTH_RST;
			height_reg = fdmd_pkg::HEIGHT_RST;
			clear_frame_state();
			report_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
			if (out_valid && !out_stall) check_report();
			if (in_valid && !in_stall) score_pixel(pixel_first, pixel_second);
		end
		pending_reports <= report_q.size();
		failures <= fail_total;
	end

endmodule

// File: tb/frame_difference_motion_detect_tb.sv
// ----------------------------------------------------------------------------
// frame_difference_motion_detect_tb
// Drives pixel pairs and register writes into the motion detector, with
// random gaps on the input and random stalls on the output. A checker beside
// the block predicts and compares every frame report; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module frame_difference_motion_detect_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_WIDTH   = 2048;
	localparam int unsigned MAX_HEIGHT  = 2048;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned DRAIN_WAIT  = 6;
	localparam int unsigned PW          = fdmd_pkg::PIXEL_W;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                psel, penable, pwrite;
	logic [fdmd_pkg::CFG_ADDR_W-1:0]     paddr;
	logic [fdmd_pkg::CFG_DATA_W-1:0]     pwdata;
	logic [fdmd_pkg::CFG_DATA_W-1:0]     prdata;
	logic                                pready;
	logic                                in_valid, in_stall;
	logic [PW-1:0]                       pixel_first, pixel_second;
	logic                                out_valid, out_stall;
	logic                                motion_detected;
	logic [fdmd_pkg::COUNT_W-1:0]        changed_count;
	logic [$clog2(MAX_WIDTH + 1)-1:0]    box_left;
	logic [$clog2(MAX_HEIGHT + 1)-1:0]   box_top;
	logic [$clog2(MAX_WIDTH)-1:0]        box_right;
	logic [$clog2(MAX_HEIGHT)-1:0]       box_bottom;
	int                                  failures, pending_reports;
	int                                  send_idle = 0;
	int                                  recv_idle = 0;

	frame_difference_motion_detect #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_first(pixel_first), .pixel_second(pixel_second),
		.out_valid(out_valid), .out_stall(out_stall),
		.motion_detected(motion_detected), .changed_count(changed_count),
		.box_left(box_left), .box_top(box_top),
		.box_right(box_right), .box_bottom(box_bottom)
	);

	fdmd_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pixel_first(pixel_first), .pixel_second(pixel_second),
		.out_valid(out_valid), .out_stall(out_stall),
		.motion_detected(motion_detected), .changed_count(changed_count),
		.box_left(box_left), .box_top(box_top),
		.box_right(box_right), .box_bottom(box_bottom),
		.failures(failures), .pending_reports(pending_reports)
	);

	always begin
		#10ns clk = 1'b1;
		#10ns clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic cfg_write(input fdmd_pkg::reg_index_t idx,
			input logic [fdmd_pkg::CFG_DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Drops valid, waits for every expected report, then lets the pipeline
	// drain so that a frame still in flight is scored before a write.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_reports != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Valid is left high after the handshake; the next call either keeps it
	// high with a new word or drops it for a gap.
	task automatic send_pair(input logic [PW-1:0] a, input logic [PW-1:0] b);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_first <= a;
		pixel_second <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [2*PW-1:0] random_pair();
		logic [PW-1:0] a, b;
		a = PW'($urandom);
		case ($urandom_range(7))
			0, 1:    b = PW'($urandom);
			2:       b = a;
			3:       b = ~a;
			default: b = a ^ (PW'($urandom) & PW'($urandom) & PW'($urandom));
		endcase
		return {a, b};
	endfunction

	// Grayscale frame where only a few words differ, the first and last among
	// them; the high bytes are noise that the block must ignore.
	task automatic sparse_frame(input int unsigned pixels);
		logic [PW-1:0] a, b;
		for (int unsigned i = 0; i < pixels; i++) begin
			a = PW'($urandom);
			if (i == 0 || i == pixels - 1 || $urandom_range(63) == 0)
				b = a ^ 16'h0080;
			else
				b = {8'($urandom), a[7:0]};
			send_pair(a, b);
		end
	endtask

	// New settings on a random subset of registers, then a burst of words
	// that need not line up with frame boundaries.
	task automatic random_round(output int sent);
		logic [2*PW-1:0] pair;
		int pick;
		sent = $urandom_range(20, 80);
		settle();
		if ($urandom_range(1)) cfg_write(fdmd_pkg::REG_PIXEL_MODE, $urandom_range(1));
		if ($urandom_range(1)) begin
			pick = $urandom_range(9);
			cfg_write(fdmd_pkg::REG_LEVEL_THRESHOLD, (pick == 0) ? 0 : (pick == 1) ? 255 :
				(pick == 2) ? $urandom_range(255) : $urandom_range(60));
		end
		if ($urandom_range(1)) begin
			pick = $urandom_range(9);
			cfg_write(fdmd_pkg::REG_COUNT_THRESHOLD, (pick == 0) ? 0 :
				(pick == 1) ? fdmd_pkg::COUNT_LIMIT : $urandom_range(30));
		end
		if ($urandom_range(1)) begin
			pick = $urandom_range(19);
			cfg_write(fdmd_pkg::REG_FRAME_WIDTH, (pick == 0) ? 0 : (pick == 1) ?
				$urandom_range(MAX_WIDTH + 1, 4095) : (pick == 2) ? 1 : $urandom_range(2, 8));
		end
		if ($urandom_range(1)) begin
			pick = $urandom_range(19);
			cfg_write(fdmd_pkg::REG_FRAME_HEIGHT, (pick == 0) ? 0 : (pick == 1) ?
				$urandom_range(MAX_HEIGHT + 1, 4095) : (pick == 2) ? 1 : $urandom_range(2, 6));
		end
		repeat (sent) begin
			pair = random_pair();
			send_pair(pair[2*PW-1:PW], pair[PW-1:0]);
		end
	endtask

	initial begin
		int sent, random_items;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		pixel_first <= '0;
		pixel_second <= '0;
		send_idle <= 28;
		recv_idle <= 58;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: full-range words, each RGB565 channel alone, and
		// a difference sitting on the level and one just above it.
		send_pair(16'h0000, 16'hFFFF);
		send_pair(16'hFFFF, 16'h0000);
		send_pair(16'h0000, 16'h0000);
		send_pair(16'hF800, 16'h0000);
		send_pair(16'h07E0, 16'h0000);
		send_pair(16'h0014, 16'h0000);
		send_pair(16'h0000, 16'h0015);
		// Shrinking the width mid-frame ends the current row at once.
		settle();
		cfg_write(fdmd_pkg::REG_FRAME_WIDTH, 3);
		cfg_write(fdmd_pkg::REG_FRAME_HEIGHT, 2);
		send_pair(16'h1234, 16'h1234);
		send_pair(16'h8000, 16'h0000);
		send_pair(16'h0000, 16'h0001);
		send_pair(16'hFFFF, 16'hFFFF);
		// Zero sizes act as a single pixel; grayscale ignores the high bytes.
		settle();
		cfg_write(fdmd_pkg::REG_PIXEL_MODE, 1);
		cfg_write(fdmd_pkg::REG_LEVEL_THRESHOLD, 0);
		cfg_write(fdmd_pkg::REG_COUNT_THRESHOLD, 0);
		cfg_write(fdmd_pkg::REG_FRAME_WIDTH, 0);
		cfg_write(fdmd_pkg::REG_FRAME_HEIGHT, 0);
		send_pair(16'hFF00, 16'h0000);
		send_pair(16'h0000, 16'h00FF);
		send_pair(16'hAB12, 16'hCD13);
		// Highest level: no gray difference can exceed it, so the box is empty.
		settle();
		cfg_write(fdmd_pkg::REG_LEVEL_THRESHOLD, 255);
		cfg_write(fdmd_pkg::REG_COUNT_THRESHOLD, fdmd_pkg::COUNT_LIMIT);
		cfg_write(fdmd_pkg::REG_FRAME_WIDTH, 2);
		cfg_write(fdmd_pkg::REG_FRAME_HEIGHT, 1);
		send_pair(16'h00FF, 16'h0000);
		send_pair(16'h0000, 16'h00FF);
		settle();
		cfg_write(fdmd_pkg::REG_LEVEL_THRESHOLD, 254);
		send_pair(16'h00FF, 16'h0000);
		send_pair(16'h0000, 16'h00FE);
		// The largest RGB565 difference is 125.
		settle();
		cfg_write(fdmd_pkg::REG_PIXEL_MODE, 0);
		cfg_write(fdmd_pkg::REG_LEVEL_THRESHOLD, 124);
		cfg_write(fdmd_pkg::REG_COUNT_THRESHOLD, 0);
		send_pair(16'hFFFF, 16'h0000);
		send_pair(16'hF7FF, 16'h0000);

		// One full-width row, then one full-height column with the height
		// above the maximum; the zero size acts as one.
		settle();
		cfg_write(fdmd_pkg::REG_PIXEL_MODE, 1);
		cfg_write(fdmd_pkg::REG_LEVEL_THRESHOLD, 100);
		cfg_write(fdmd_pkg::REG_COUNT_THRESHOLD, 1);
		cfg_write(fdmd_pkg::REG_FRAME_WIDTH, MAX_WIDTH);
		cfg_write(fdmd_pkg::REG_FRAME_HEIGHT, 0);
		sparse_frame(MAX_WIDTH);
		settle();
		cfg_write(fdmd_pkg::REG_FRAME_WIDTH, 0);
		cfg_write(fdmd_pkg::REG_FRAME_HEIGHT, 4095);
		sparse_frame(MAX_HEIGHT);

		for (int stage = 0; stage < 3; stage++) begin
			if (stage == 1) begin
				send_idle <= 58;
				recv_idle <= 28;
			end else if (stage == 2) begin
				send_idle <= 0;
				recv_idle <= 0;
			end
			random_items = 0;
			while (random_items < 590) begin
				random_round(sent);
				random_items += sent;
			end
		end

		settle();
		if (failures == 0 && pending_reports == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: frame_difference_motion_detect.f
hdl/fdmd_pkg.sv
hdl/fdmd_regs.sv
hdl/fdmd_diff.sv
hdl/fdmd_accum.sv
hdl/frame_difference_motion_detect.sv
tb/fdmd_checker.sv
tb/frame_difference_motion_detect_tb.sv
